/* hw/rtl/ufx_pkg.sv */
// Types, character constants and small helpers shared by the form field extractor.
// No dependencies; compiled first.
package ufx_pkg;

  localparam int MaxRes   = 3;   // results one item can cause
  localparam int ResCntW  = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 64;
  localparam int CapW     = 7;
  localparam int KeyLenW  = 4;

  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharPct    = 8'h25;
  localparam logic [7:0] CharEq     = 8'h3D;
  localparam logic [7:0] CharAmp    = 8'h26;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharDig0   = 8'h30;
  localparam logic [7:0] CharDig9   = 8'h39;
  localparam logic [7:0] CharLowA   = 8'h61;
  localparam logic [7:0] CharLowF   = 8'h66;
  localparam logic [7:0] CharUpA    = 8'h41;
  localparam logic [7:0] CharUpF    = 8'h46;
  localparam logic [CapW-1:0] CapReset = 7'd16;

  typedef enum logic [1:0] {
    PhName  = 2'd0,
    PhValue = 2'd1,
    PhSkip  = 2'd2,
    PhDone  = 2'd3
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgKeyLength = 2'd0,
    CfgKeyText   = 2'd1,
    CfgCapacity  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] body_byte;
    logic       end_of_body;
  } in_item_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       is_status;
    logic       found;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] value;
  } cfg_item_t;

  // {digit valid, nibble}
  function automatic logic [4:0] hex_decode(logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= CharDig0 && c <= CharDig9) begin
      r = {1'b1, 4'(c - CharDig0)};
    end else if (c >= CharLowA && c <= CharLowF) begin
      r = {1'b1, 4'(c - CharLowA + 8'd10)};
    end else if (c >= CharUpA && c <= CharUpF) begin
      r = {1'b1, 4'(c - CharUpA + 8'd10)};
    end
    return r;
  endfunction

endpackage

/* hw/rtl/ufx_if.sv */
// Valid/ready channel interfaces for body items, results and register writes.
// Depends on ufx_pkg.
interface ufx_in_if import ufx_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ufx_out_if import ufx_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ufx_cfg_if import ufx_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/urlencoded_form_field_extractor_core.sv */
// Form field extractor: scans a URL-encoded body one byte per item and returns the decoded
// value of the first field whose name equals the key, then a status word at body end.
// Depends on ufx_pkg, the ufx_*_if channel interfaces and ufx_res_buf.
// An accepted item is held in the input register, then its results are loaded into the
// result register, which presents the first of them. Items causing zero or one result
// flow at one per cycle while the result port is not stalled; an item causing k results
// (k up to 3: a bad or cut escape, or the status word) holds a following item with
// results in the input register while the single result port drains them.
// Register writes are always taken.
module urlencoded_form_field_extractor_core import ufx_pkg::*; #(
  parameter int KEY_MAX   = 8,
  parameter int VALUE_MAX = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ufx_cfg_if.sink   cfg_i,
  ufx_in_if.sink    in_i,
  ufx_out_if.source out_o
);

  localparam int PosW  = $clog2(KEY_MAX + 1);
  localparam int KIdxW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int CntW  = $clog2(VALUE_MAX + 1);

  // configuration
  logic [KeyLenW-1:0]   key_length_q;
  logic [8*KEY_MAX-1:0] key_text_q;
  logic [CapW-1:0]      capacity_q;
  logic [PosW-1:0]      klen;
  logic [CntW-1:0]      cap_eff;

  // input register
  in_item_t in_q;
  logic     in_vld_q;
  logic     in_acc;
  logic     proc;

  // scan state
  phase_e          phase_q, phase_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            mis_q, mis_d;
  logic [1:0]      ec_q, ec_d;
  logic [7:0]      ed_q, ed_d;
  logic [CntW-1:0] vc_q, vc_d;

  result_t [MaxRes-1:0] res_d;
  logic [ResCntW-1:0]   nres;
  logic                 space;
  logic [7:0]           b;
  logic [7:0]           key_byte;
  logic [4:0]           hi;
  logic [4:0]           lo;

  function automatic logic room(logic [CntW-1:0] vc, logic [CntW-1:0] cap);
    return ({1'b0, vc} + (CntW+1)'(1)) < {1'b0, cap};
  endfunction

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q <= '0;
      key_text_q   <= '0;
      capacity_q   <= CapReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        CfgKeyLength: key_length_q <= cfg_i.data.value[KeyLenW-1:0];
        CfgKeyText:   key_text_q   <= cfg_i.data.value[8*KEY_MAX-1:0];
        CfgCapacity:  capacity_q   <= cfg_i.data.value[CapW-1:0];
        default: ;
      endcase
    end
  end

  assign klen    = (key_length_q > KeyLenW'(KEY_MAX)) ? PosW'(KEY_MAX)
                                                      : key_length_q[PosW-1:0];
  assign cap_eff = (capacity_q > CapW'(VALUE_MAX)) ? CntW'(VALUE_MAX)
                                                   : capacity_q[CntW-1:0];

  assign b        = in_q.body_byte;
  assign key_byte = key_text_q[{pos_q[KIdxW-1:0], 3'b000} +: 8];
  assign hi       = hex_decode(ed_q);
  assign lo       = hex_decode(b);

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    mis_d   = mis_q;
    ec_d    = ec_q;
    ed_d    = ed_q;
    vc_d    = vc_q;
    res_d   = '0;
    nres    = '0;

    if (in_q.has_byte) begin
      case (phase_q)
        PhName: begin
          if (b == CharEq) begin
            if (!mis_q && pos_q == klen) begin
              phase_d = PhValue;
              vc_d    = '0;
              ec_d    = '0;
              ed_d    = '0;
            end else begin
              phase_d = PhSkip;
            end
          end else if (!mis_q) begin
            if (pos_q < klen && key_byte == b) begin
              pos_d = pos_q + PosW'(1);
            end else begin
              mis_d = 1'b1;
            end
          end
        end
        PhValue: begin
          if (b != CharAmp) begin
            case (ec_q)
              2'd0: begin
                if (b == CharPct) begin
                  if (room(vc_d, cap_eff)) ec_d = 2'd1;
                end else if (room(vc_d, cap_eff)) begin
                  if (nres != ResCntW'(MaxRes)) begin
                    res_d[nres].value_byte = (b == CharPlus) ? CharSpace : b;
                    nres = nres + ResCntW'(1);
                  end
                  vc_d = vc_d + CntW'(1);
                end
              end
              2'd1: begin
                ed_d = b;
                ec_d = 2'd2;
              end
              default: begin
                ec_d = '0;
                ed_d = '0;
                if (hi[4] && lo[4]) begin
                  if (room(vc_d, cap_eff)) begin
                    if (nres != ResCntW'(MaxRes)) begin
                      res_d[nres].value_byte = {hi[3:0], lo[3:0]};
                      nres = nres + ResCntW'(1);
                    end
                    vc_d = vc_d + CntW'(1);
                  end
                end else begin
                  // bad escape: drop the '%', replay both bytes as fresh bytes
                  if (ed_q == CharPct) begin
                    if (room(vc_d, cap_eff)) ec_d = 2'd1;
                  end else if (room(vc_d, cap_eff)) begin
                    if (nres != ResCntW'(MaxRes)) begin
                      res_d[nres].value_byte = (ed_q == CharPlus) ? CharSpace : ed_q;
                      nres = nres + ResCntW'(1);
                    end
                    vc_d = vc_d + CntW'(1);
                  end
                  if (ec_d == 2'd1) begin
                    ed_d = b;
                    ec_d = 2'd2;
                  end else if (b == CharPct) begin
                    if (room(vc_d, cap_eff)) ec_d = 2'd1;
                  end else if (room(vc_d, cap_eff)) begin
                    if (nres != ResCntW'(MaxRes)) begin
                      res_d[nres].value_byte = (b == CharPlus) ? CharSpace : b;
                      nres = nres + ResCntW'(1);
                    end
                    vc_d = vc_d + CntW'(1);
                  end
                end
              end
            endcase
          end
        end
        PhSkip: begin
          if (b == CharAmp) begin
            phase_d = PhName;
            pos_d   = '0;
            mis_d   = 1'b0;
          end
        end
        default: ;
      endcase
    end

    // value ends at '&' or body end; a cut escape keeps its '%' literally
    if (phase_d == PhValue &&
        ((in_q.has_byte && b == CharAmp) || in_q.end_of_body)) begin
      if (ec_d != 2'd0) begin
        if (room(vc_d, cap_eff)) begin
          if (nres != ResCntW'(MaxRes)) begin
            res_d[nres].value_byte = CharPct;
            nres = nres + ResCntW'(1);
          end
          vc_d = vc_d + CntW'(1);
        end
        if (ec_d == 2'd2 && room(vc_d, cap_eff)) begin
          if (nres != ResCntW'(MaxRes)) begin
            res_d[nres].value_byte = (ed_d == CharPlus) ? CharSpace : ed_d;
            nres = nres + ResCntW'(1);
          end
          vc_d = vc_d + CntW'(1);
        end
      end
      ec_d    = '0;
      ed_d    = '0;
      phase_d = PhDone;
    end

    if (in_q.end_of_body) begin
      if (nres != ResCntW'(MaxRes)) begin
        res_d[nres].is_status = 1'b1;
        res_d[nres].found     = (phase_d == PhDone) && (cap_eff != '0);
        nres = nres + ResCntW'(1);
      end
      phase_d = PhName;
      pos_d   = '0;
      mis_d   = 1'b0;
      ec_d    = '0;
      ed_d    = '0;
      vc_d    = '0;
    end

    if (nres != '0) begin
      res_d[nres - ResCntW'(1)].last = 1'b1;
    end
  end

  // items without results never wait for the result register
  assign proc       = in_vld_q && ((nres == '0) || space);
  assign in_i.ready = !in_vld_q || proc;
  assign in_acc     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      phase_q  <= PhName;
      pos_q    <= '0;
      mis_q    <= 1'b0;
      ec_q     <= '0;
      ed_q     <= '0;
      vc_q     <= '0;
    end else begin
      if (in_acc) begin
        in_vld_q <= 1'b1;
      end else if (proc) begin
        in_vld_q <= 1'b0;
      end
      if (proc) begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        mis_q   <= mis_d;
        ec_q    <= ec_d;
        ed_q    <= ed_d;
        vc_q    <= vc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_i.data;
    end
  end

  ufx_res_buf u_res_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (proc && (nres != '0)),
    .load_cnt_i  (nres),
    .load_data_i (res_d),
    .space_o     (space),
    .out_o       (out_o)
  );

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.is_status) |-> out_o.data.last)
    else $error("status word not marked last");

  a_value_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.data.is_status) |-> !out_o.data.found)
    else $error("value byte carries found flag");

  a_body_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && in_q.end_of_body) |=> (phase_q == PhName && vc_q == '0 && ec_q == '0))
    else $error("scan state not cleared at body end");

endmodule

/* hw/rtl/ufx_res_buf.sv */
// Result register: holds up to three results of one item and drains them in order.
// Depends on ufx_pkg and ufx_out_if.
module ufx_res_buf import ufx_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     load_i,
  input  logic [ResCntW-1:0]       load_cnt_i,
  input  result_t [MaxRes-1:0]     load_data_i,
  output logic                     space_o,
  ufx_out_if.source                out_o
);

  logic [ResCntW-1:0]   cnt_q, cnt_d;
  result_t [MaxRes-1:0] ent_q, ent_d;
  logic                 pop;

  assign pop         = out_o.valid && out_o.ready;
  assign out_o.valid = (cnt_q != '0);
  assign out_o.data  = ent_q[0];
  // room for a new set once the last pending result leaves this cycle
  assign space_o     = (cnt_q == '0) || ((cnt_q == ResCntW'(1)) && out_o.ready);

  always_comb begin
    cnt_d = cnt_q;
    ent_d = ent_q;
    if (load_i) begin
      cnt_d = load_cnt_i;
      ent_d = load_data_i;
    end else if (pop) begin
      cnt_d = cnt_q - ResCntW'(1);
      for (int i = 0; i < MaxRes - 1; i++) begin
        ent_d[i] = ent_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  a_load_has_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> space_o)
    else $error("result set loaded over pending results");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && load_cnt_i != '0) |=> out_o.valid)
    else $error("loaded results not presented");

  a_drain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && cnt_q == ResCntW'(1) && !load_i) |=> !out_o.valid)
    else $error("result shown after buffer drained");

endmodule
